FILE: hdl/multi_channel_fifo_audio_mixer_assert.svh
// Assertion macros for the mixer checker.
// Each macro takes a label, an antecedent, a consequent and a message.
// The including scope must provide i_clk and i_rst_n.
`ifndef MULTI_CHANNEL_FIFO_AUDIO_MIXER_ASSERT_SVH
`define MULTI_CHANNEL_FIFO_AUDIO_MIXER_ASSERT_SVH

// Same-cycle implication.
`define MCFAM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MCFAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mcfam_pkg.sv
package mcfam_pkg;

    localparam int CHANNELS   = 8;
    localparam int FIFO_DEPTH = 4096;

    localparam int CH_FIELD_W = 3;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int FILL_W     = 13;
    localparam int STATUS_W   = 2;
    localparam int BANK_W     = 64;
    localparam int ACTIVE_W   = 8;
    localparam int CFG_IDX_W  = 2;

    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_DEPTH = CHANNELS * FIFO_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // signed sample times unsigned gain, then a sum over all channels
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(CHANNELS) + 1;

    // output = sum / 20480 = (sum / 2^12) / 5, rounded half away from zero
    localparam int MIX_SHIFT   = 12;
    localparam int MIX_ODD     = 5;
    localparam int MIX_HALF    = 10240;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / MIX_ODD;
    localparam int RECIP_W     = $clog2(RECIP + 1);

    localparam int MIX_POS_LIM = 32767;
    localparam int MIX_NEG_LIM = 32768;
    localparam logic signed [SAMPLE_W-1:0] MIX_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] MIX_MIN = 16'sh8000;

    localparam logic MODE_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd2;

    localparam logic [BANK_W-1:0]   GAIN_RESET   = 64'h4000_4000_4000_4000;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 8'hFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_INACTIVE = 2'd2
    } t_status;

    typedef struct packed {
        logic                       push;
        logic                       pop;
        logic signed [SAMPLE_W-1:0] data;
    } t_fifo_cmd;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] q;
        logic                       clip;
    } t_mix_res;

endpackage

FILE: hdl/mcfam_fifo_bank.sv
module mcfam_fifo_bank (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [mcfam_pkg::CH_IDX_W-1:0]         i_ch,
    input  mcfam_pkg::t_fifo_cmd                   i_cmd,
    output logic [mcfam_pkg::CNT_W-1:0]            o_count,
    output logic signed [mcfam_pkg::SAMPLE_W-1:0]  o_rdata,
    output logic                                   o_rd_valid
);
    import mcfam_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [MEM_DEPTH];
    logic [PTR_W-1:0] r_rp [CHANNELS];
    logic [PTR_W-1:0] r_wp [CHANNELS];
    logic [CNT_W-1:0] r_count [CHANNELS];
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic r_rd_valid;

    logic             do_push;
    logic             do_pop;
    logic [PTR_W-1:0] ptr;
    logic [ADDR_W-1:0] addr;

    assign o_count = r_count[i_ch];
    assign do_push = i_cmd.push && (o_count < CNT_W'(FIFO_DEPTH));
    assign do_pop  = i_cmd.pop && (o_count != '0);
    assign ptr     = i_cmd.push ? r_wp[i_ch] : r_rp[i_ch];
    assign addr    = ADDR_W'(i_ch) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(ptr);

    // single port: a push and a pop never share a cycle
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[addr] <= i_cmd.data;
        end
        r_rdata <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_rp[c]    <= '0;
                r_wp[c]    <= '0;
                r_count[c] <= '0;
            end
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= do_pop;
            if (do_push) begin
                r_wp[i_ch]    <= (r_wp[i_ch] == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : r_wp[i_ch] + 1'b1;
                r_count[i_ch] <= r_count[i_ch] + 1'b1;
            end else if (do_pop) begin
                r_rp[i_ch]    <= (r_rp[i_ch] == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : r_rp[i_ch] + 1'b1;
                r_count[i_ch] <= r_count[i_ch] - 1'b1;
            end
        end
    end

    assign o_rdata    = r_rdata;
    assign o_rd_valid = r_rd_valid;

endmodule

FILE: hdl/mcfam_mac.sv
module mcfam_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_clr,
    input  logic                                  i_valid,
    input  logic signed [mcfam_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [mcfam_pkg::GAIN_W-1:0]          i_gain,
    output logic signed [mcfam_pkg::ACC_W-1:0]    o_acc
);
    import mcfam_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic signed [ACC_W-1:0]  r_acc;

    // the one multiplier, registered before the accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_sample * $signed({1'b0, i_gain}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_prod_v <= i_valid && !i_clr;
            if (i_clr) begin
                r_acc <= '0;
            end else if (r_prod_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: hdl/mcfam_round.sv
module mcfam_round (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [mcfam_pkg::ACC_W-1:0] i_sum,
    output mcfam_pkg::t_mix_res                o_res
);
    import mcfam_pkg::*;

    localparam int MAG_W  = ACC_W + 1;
    localparam int Y_W    = MAG_W - MIX_SHIFT;
    localparam int MUL_W  = Y_W + RECIP_W;
    localparam int Q_W    = MUL_W - RECIP_SHIFT;

    logic [ACC_W-1:0] mag;
    logic [MAG_W-1:0] biased;

    logic [Y_W-1:0]   r_y;
    logic [Y_W-1:0]   r_y2;
    logic [MUL_W-1:0] r_mul;
    logic             r_neg;
    logic             r_neg2;
    logic             r_v1;
    logic             r_v2;
    t_mix_res         r_res;

    logic [Q_W-1:0] q0;
    logic [Y_W-1:0] rem;
    logic [Q_W-1:0] q;

    assign mag    = i_sum[ACC_W-1] ? ACC_W'(-i_sum) : ACC_W'(i_sum);
    assign biased = MAG_W'(mag) + MAG_W'(MIX_HALF);

    // quotient estimate is low by at most one; fix it from the remainder
    assign q0  = r_mul[MUL_W-1:RECIP_SHIFT];
    assign rem = r_y2 - (Y_W'(q0) << 2) - Y_W'(q0);
    assign q   = q0 + Q_W'(rem >= Y_W'(MIX_ODD));

    always_ff @(posedge i_clk) begin
        r_y    <= biased[MAG_W-1:MIX_SHIFT];
        r_neg  <= i_sum[ACC_W-1];
        r_mul  <= MUL_W'(r_y * RECIP_W'(RECIP));
        r_y2   <= r_y;
        r_neg2 <= r_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_res <= '0;
        end else begin
            r_v1       <= i_start;
            r_v2       <= r_v1;
            r_res.done <= r_v2;
            if (r_v2) begin
                if (r_neg2) begin
                    r_res.clip <= q > Q_W'(MIX_NEG_LIM);
                    r_res.q    <= (q > Q_W'(MIX_NEG_LIM)) ? MIX_MIN
                                                          : SAMPLE_W'(-q[SAMPLE_W-1:0]);
                end else begin
                    r_res.clip <= q > Q_W'(MIX_POS_LIM);
                    r_res.q    <= (q > Q_W'(MIX_POS_LIM)) ? MIX_MAX
                                                          : $signed(q[SAMPLE_W-1:0]);
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

FILE: hdl/multi_channel_fifo_audio_mixer.sv
// Channel   Signals                                          Direction
// input     i_in_valid / o_in_stall, i_mode, i_channel,      in
//           i_sample_in
// output    o_out_valid / i_out_stall, o_write_status,       out
//           o_mixed_sample, o_clipped, o_fill_level
// config    i_cfg_we, i_cfg_index, i_cfg_data                in
//
// A push beat writes the FIFO memory in S_PUSH, then hands off to the output
// register from S_DONE. A tick issues one memory read and one multiply per
// channel through the single shared MAC in S_ISSUE, drains the pipeline in
// S_DRAIN, scales and rounds, then hands off. Synchronous active-low reset
// clears pointers, fill counts and config, not the sample memory.
// o_in_stall is high while a beat is in flight or its result waits for the output register.
module multi_channel_fifo_audio_mixer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_mode,
    input  logic [mcfam_pkg::CH_FIELD_W-1:0]       i_channel,
    input  logic signed [mcfam_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [mcfam_pkg::STATUS_W-1:0]         o_write_status,
    output logic signed [mcfam_pkg::SAMPLE_W-1:0]  o_mixed_sample,
    output logic                                   o_clipped,
    output logic [mcfam_pkg::FILL_W-1:0]           o_fill_level,
    input  logic                                   i_cfg_we,
    input  logic [mcfam_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mcfam_pkg::BANK_W-1:0]           i_cfg_data
);
    import mcfam_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_ISSUE,
        S_DRAIN,
        S_ROUND,
        S_DONE
    } t_state;

    // ---------------- configuration ----------------
    logic [BANK_W-1:0]   r_gain_a;
    logic [BANK_W-1:0]   r_gain_b;
    logic [ACTIVE_W-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_a <= GAIN_RESET;
            r_gain_b <= GAIN_RESET;
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN_A: r_gain_a <= i_cfg_data;
                CFG_GAIN_B: r_gain_b <= i_cfg_data;
                CFG_ACTIVE: r_active <= i_cfg_data[ACTIVE_W-1:0];
                default:    ;  // drop writes to unused indexes
            endcase
        end
    end

    // ---------------- sequencer state ----------------
    t_state                     r_state, n_state;
    logic [CH_FIELD_W-1:0]      r_channel, n_channel;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic [CH_IDX_W-1:0]        r_ch, n_ch;
    logic [1:0]                 r_drain, n_drain;
    logic [STATUS_W-1:0]        r_res_status, n_res_status;
    logic signed [SAMPLE_W-1:0] r_res_mixed, n_res_mixed;
    logic                       r_res_clip, n_res_clip;
    logic [FILL_W-1:0]          r_res_fill, n_res_fill;
    logic                       r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]        r_out_status, n_out_status;
    logic signed [SAMPLE_W-1:0] r_out_mixed, n_out_mixed;
    logic                       r_out_clip, n_out_clip;
    logic [FILL_W-1:0]          r_out_fill, n_out_fill;

    logic [GAIN_W-1:0] r_gain_d;

    // ---------------- datapath hookups ----------------
    logic [CH_IDX_W-1:0]        fifo_ch;
    t_fifo_cmd                  fifo_cmd;
    logic [CNT_W-1:0]           fifo_count;
    logic signed [SAMPLE_W-1:0] fifo_rdata;
    logic                       fifo_rd_valid;
    logic                       mac_clr;
    logic signed [ACC_W-1:0]    mac_acc;
    logic                       round_start;
    t_mix_res                   round_res;

    logic                       in_accept;
    logic                       ch_ok;
    logic                       push_active;
    logic                       issue_active;
    logic [2*BANK_W-1:0]        gain_all;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign ch_ok        = int'(r_channel) < CHANNELS;
    assign push_active  = r_active[r_channel];
    assign issue_active = r_active[CH_FIELD_W'(r_ch)];
    assign gain_all     = {r_gain_b, r_gain_a};

    // the FIFO bank looks at the pushed channel, or at the channel being swept
    assign fifo_ch = (r_state == S_PUSH) ? r_channel[CH_IDX_W-1:0] : r_ch;

    // gain is registered like the memory read so it meets its sample
    always_ff @(posedge i_clk) begin
        r_gain_d <= gain_all[GAIN_W*int'(r_ch) +: GAIN_W];
    end

    always_comb begin
        n_state      = r_state;
        n_channel    = r_channel;
        n_sample     = r_sample;
        n_ch         = r_ch;
        n_drain      = r_drain;
        n_res_status = r_res_status;
        n_res_mixed  = r_res_mixed;
        n_res_clip   = r_res_clip;
        n_res_fill   = r_res_fill;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_mixed  = r_out_mixed;
        n_out_clip   = r_out_clip;
        n_out_fill   = r_out_fill;
        fifo_cmd     = '{push: 1'b0, pop: 1'b0, data: r_sample};
        mac_clr      = 1'b0;
        round_start  = 1'b0;

        // retire the waiting result once the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_channel = i_channel;
                    n_sample  = i_sample_in;
                    if (i_mode == MODE_TICK) begin
                        n_ch    = '0;
                        mac_clr = 1'b1;
                        n_state = S_ISSUE;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                n_res_mixed = '0;
                n_res_clip  = 1'b0;
                if (!ch_ok) begin
                    n_res_status = ST_INACTIVE;
                    n_res_fill   = '0;
                end else if (!push_active) begin
                    n_res_status = ST_INACTIVE;
                    n_res_fill   = FILL_W'(fifo_count);
                end else if (fifo_count >= CNT_W'(FIFO_DEPTH)) begin
                    n_res_status = ST_FULL;
                    n_res_fill   = FILL_W'(fifo_count);
                end else begin
                    fifo_cmd.push = 1'b1;
                    n_res_status  = ST_OK;
                    n_res_fill    = FILL_W'(fifo_count + 1'b1);
                end
                n_state = S_DONE;
            end
            S_ISSUE: begin
                // pop only live channels; empty or muted ones add nothing
                fifo_cmd.pop = issue_active && (fifo_count != '0);
                if (r_ch == CH_IDX_W'(CHANNELS - 1)) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            S_DRAIN: begin
                // wait out memory read, multiply and accumulate
                n_drain = r_drain + 1'b1;
                if (r_drain == 2'd3) begin
                    round_start = 1'b1;
                    n_state     = S_ROUND;
                end
            end
            S_ROUND: begin
                if (round_res.done) begin
                    n_res_status = ST_OK;
                    n_res_mixed  = round_res.q;
                    n_res_clip   = round_res.clip;
                    n_res_fill   = '0;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_mixed  = r_res_mixed;
                    n_out_clip   = r_res_clip;
                    n_out_fill   = r_res_fill;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
        r_channel    <= n_channel;
        r_sample     <= n_sample;
        r_res_status <= n_res_status;
        r_res_mixed  <= n_res_mixed;
        r_res_clip   <= n_res_clip;
        r_res_fill   <= n_res_fill;
        r_out_status <= n_out_status;
        r_out_mixed  <= n_out_mixed;
        r_out_clip   <= n_out_clip;
        r_out_fill   <= n_out_fill;
    end

    mcfam_fifo_bank u_fifo_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ch       (fifo_ch),
        .i_cmd      (fifo_cmd),
        .o_count    (fifo_count),
        .o_rdata    (fifo_rdata),
        .o_rd_valid (fifo_rd_valid)
    );

    mcfam_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (mac_clr),
        .i_valid  (fifo_rd_valid),
        .i_sample (fifo_rdata),
        .i_gain   (r_gain_d),
        .o_acc    (mac_acc)
    );

    mcfam_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (round_start),
        .i_sum   (mac_acc),
        .o_res   (round_res)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_write_status = r_out_status;
    assign o_mixed_sample = r_out_mixed;
    assign o_clipped      = r_out_clip;
    assign o_fill_level   = r_out_fill;

endmodule

FILE: hdl/mcfam_checker.sv
`include "multi_channel_fifo_audio_mixer_assert.svh"

module mcfam_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic [mcfam_pkg::STATUS_W-1:0]         o_write_status,
    input logic signed [mcfam_pkg::SAMPLE_W-1:0]  o_mixed_sample,
    input logic                                   o_clipped,
    input logic [mcfam_pkg::FILL_W-1:0]           o_fill_level
);
    import mcfam_pkg::*;

    // a stalled result beat stays put
    `MCFAM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_mixed_sample) && $stable(o_fill_level), "output beat changed while stalled")

    // a refused or dropped push result never carries mix data
    `MCFAM_ASSERT_NOW(a_push_quiet, o_out_valid && o_write_status != ST_OK, o_mixed_sample == '0 && !o_clipped, "push result carries mix data")

    // clipping only at the rails, and only on a tick
    `MCFAM_ASSERT_NOW(a_clip_rail, o_out_valid && o_clipped, (o_mixed_sample == MIX_MAX || o_mixed_sample == MIX_MIN) && o_fill_level == '0, "clip flag off the rails")

    // fill never exceeds the FIFO depth
    `MCFAM_ASSERT_NOW(a_fill_bound, o_out_valid, o_fill_level <= FILL_W'(FIFO_DEPTH), "fill level past depth")

    // one beat at a time: acceptance closes the input
    `MCFAM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input open right after a beat")

endmodule

bind multi_channel_fifo_audio_mixer mcfam_checker u_mcfam_checker (.*);

FILE: tb/mixer_track_pkg.sv
package mixer_track_pkg;

    import mcfam_pkg::*;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct {
        t_status           status;
        sample_t           mixed;
        logic              clip;
        logic [FILL_W-1:0] fill;
    } mix_out_t;

    // output = sum of Q3.29 products * 0.8 / 2^14 = sum / 20480
    localparam longint MIX_DIV    = 20480;
    localparam longint ROUND_HALF = 10240;

    class audio_mix_tracker;

        logic [BANK_W-1:0]   gain_a;
        logic [BANK_W-1:0]   gain_b;
        logic [ACTIVE_W-1:0] active;
        sample_t             chan_fifo[CHANNELS][$];
        mix_out_t            due_outputs[$];

        int mismatches;
        int pushes;
        int ticks;
        int clips;
        int drops;
        int refusals;

        function new();
            gain_a     = GAIN_RESET;
            gain_b     = GAIN_RESET;
            active     = ACTIVE_RESET;
            mismatches = 0;
            pushes     = 0;
            ticks      = 0;
            clips      = 0;
            drops      = 0;
            refusals   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BANK_W-1:0] data);
            case (idx)
                CFG_GAIN_A: gain_a = data;
                CFG_GAIN_B: gain_b = data;
                CFG_ACTIVE: active = data[ACTIVE_W-1:0];
                default: ;
            endcase
        endfunction

        function int fill_of(int ch);
            return chan_fifo[ch].size();
        endfunction

        function int deepest();
            int most;
            most = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                if (chan_fifo[c].size() > most) most = chan_fifo[c].size();
            end
            return most;
        endfunction

        // Advance the channel state by one accepted input beat and queue its result.
        function void note_beat(logic mode, logic [CH_FIELD_W-1:0] ch, sample_t smp);
            mix_out_t          r;
            longint            acc;
            longint            mag;
            longint            q;
            logic [BANK_W-1:0] bank;
            logic [GAIN_W-1:0] g;
            int                c;
            r.status = ST_OK;
            r.mixed  = '0;
            r.clip   = 1'b0;
            r.fill   = '0;
            if (mode != MODE_TICK) begin
                pushes++;
                if (!active[ch]) begin
                    r.status = ST_INACTIVE;
                    r.fill   = FILL_W'(chan_fifo[ch].size());
                    refusals++;
                end else if (chan_fifo[ch].size() >= FIFO_DEPTH) begin
                    r.status = ST_FULL;
                    r.fill   = FILL_W'(chan_fifo[ch].size());
                    drops++;
                end else begin
                    chan_fifo[ch].push_back(smp);
                    r.fill = FILL_W'(chan_fifo[ch].size());
                end
            end else begin
                ticks++;
                acc = 0;
                for (c = 0; c < CHANNELS; c++) begin
                    if (active[c] && chan_fifo[c].size() != 0) begin
                        bank = (c < 4) ? gain_a : gain_b;
                        g    = bank[(c % 4) * GAIN_W +: GAIN_W];
                        acc += longint'(chan_fifo[c].pop_front()) * longint'({1'b0, g});
                    end
                end
                // round half away from zero, then saturate
                mag = (acc < 0) ? -acc : acc;
                q   = (mag + ROUND_HALF) / MIX_DIV;
                if (acc < 0) q = -q;
                if (q > MIX_POS_LIM) begin
                    q      = MIX_POS_LIM;
                    r.clip = 1'b1;
                end else if (q < -MIX_NEG_LIM) begin
                    q      = -MIX_NEG_LIM;
                    r.clip = 1'b1;
                end
                if (r.clip) clips++;
                r.mixed = sample_t'(q);
            end
            due_outputs.push_back(r);
        endfunction

        function void check_output(logic [STATUS_W-1:0] st, sample_t mixed, logic clip,
                                   logic [FILL_W-1:0] fill);
            mix_out_t want;
            if (due_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d mix %0d clip %0b fill %0d",
                             st, mixed, clip, fill);
                return;
            end
            want = due_outputs.pop_front();
            if (st !== want.status || mixed !== want.mixed || clip !== want.clip ||
                fill !== want.fill) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected status %0d mix %0d clip %0b fill %0d, got status %0d mix %0d clip %0b fill %0d",
                             want.status, want.mixed, want.clip, want.fill,
                             st, mixed, clip, fill);
            end
        endfunction

    endclass

endpackage

FILE: tb/tb_multi_channel_fifo_audio_mixer.sv
module tb_multi_channel_fifo_audio_mixer;

    timeunit 1ns;
    timeprecision 1ps;

    import mcfam_pkg::*;
    import mixer_track_pkg::*;

    localparam logic                 MODE_PUSH     = ~MODE_TICK;
    // index past the register list; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam int                   HOLD_CYCLES   = 300;
    localparam int                   STUCK_LIMIT   = 4000;
    localparam int                   SETTLE_CYCLES = 40;

    // one corner sample per channel (rails, zero, +/-1); with unit gains the sum overflows high
    localparam logic signed [SAMPLE_W-1:0] CORNER_SET [0:CHANNELS-1] = '{
        16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
        16'sh0001, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF
    };

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic                       i_mode      = 1'b0;
    logic [CH_FIELD_W-1:0]      i_channel   = '0;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [STATUS_W-1:0]        o_write_status;
    logic signed [SAMPLE_W-1:0] o_mixed_sample;
    logic                       o_clipped;
    logic [FILL_W-1:0]          o_fill_level;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_GAIN_A;
    logic [BANK_W-1:0]          i_cfg_data  = '0;

    audio_mix_tracker tracker;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;
    int   hold_left     = 0;
    int   stuck_cycles  = 0;

    multi_channel_fifo_audio_mixer i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random stall, or one long hold-off when requested so the
    // block backs up and stalls its input side.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req    = 1'b0;
            hold_left   = HOLD_CYCLES - 1;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Sample both channels at the rising edge: feed accepted input beats to
    // the predictor, compare accepted result beats against it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0)
                tracker.check_output(o_write_status, o_mixed_sample, o_clipped, o_fill_level);
            if (i_in_valid && o_in_stall === 1'b0)
                tracker.note_beat(i_mode, i_channel, i_sample_in);
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("timeout: no beat accepted for %0d cycles", STUCK_LIMIT);
                $display("[multi_channel_fifo_audio_mixer] ERROR");
                $finish;
            end
        end
    end

    // Offer one beat, idling first at random; hold the payload until accepted.
    // Valid stays high on return so back-to-back beats need no dip.
    task automatic send_beat(input logic mode, input logic [CH_FIELD_W-1:0] ch,
                             input logic signed [SAMPLE_W-1:0] smp);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_mode      = mode;
        i_channel   = ch;
        i_sample_in = smp;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // Drop valid and hold until every queued result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.due_outputs.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mixer_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [BANK_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        tracker.write_reg(idx, data);
    endtask

    task automatic configure(input logic [BANK_W-1:0] bank_a, input logic [BANK_W-1:0] bank_b,
                             input logic [ACTIVE_W-1:0] mask);
        wait_drained();
        write_mixer_reg(CFG_GAIN_A, bank_a);
        write_mixer_reg(CFG_GAIN_B, bank_b);
        write_mixer_reg(CFG_ACTIVE, mask);
    endtask

    // Mostly random samples, with the rails and zero mixed in.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Each gain spans the full Q2.14 range or, at even odds, stays at or below unity.
    function automatic logic [BANK_W-1:0] random_gain_bank();
        logic [BANK_W-1:0] bank;
        int                k;
        for (k = 0; k < 4; k++)
            bank[k * GAIN_W +: GAIN_W] = ($urandom_range(1) != 0) ? GAIN_W'($urandom)
                                                                   : GAIN_W'($urandom_range(0, 16'h4000));
        return bank;
    endfunction

    task automatic run_random(input int count, input int tick_pct);
        int n;
        for (n = 0; n < count; n++)
            send_beat(($urandom_range(99) < tick_pct) ? MODE_TICK : MODE_PUSH,
                      CH_FIELD_W'($urandom), pick_sample());
    endtask

    initial begin
        int c;
        int seg;

        tracker = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners at reset settings: unit gains, all channels live.
        send_beat(MODE_TICK, 3'd0, 16'sh0000);               // nothing to mix
        for (c = 0; c < CHANNELS; c++)
            send_beat(MODE_PUSH, CH_FIELD_W'(c), CORNER_SET[c]);
        send_beat(MODE_TICK, 3'd7, 16'sh7FFF);               // saturates high
        for (c = 0; c < CHANNELS; c++)
            send_beat(MODE_PUSH, CH_FIELD_W'(c), MIX_MIN);
        configure('1, '1, ACTIVE_RESET);
        send_beat(MODE_TICK, 3'd2, 16'sh8000);               // saturates low at max gain

        // Rounding ties: 5 * 2048 lands exactly on half an output step.
        configure(64'h0000_0000_0000_0800, '0, ACTIVE_RESET);
        send_beat(MODE_PUSH, 3'd0, 16'sh0005);
        send_beat(MODE_PUSH, 3'd0, -16'sh0005);
        send_beat(MODE_PUSH, 3'd4, 16'sh1234);
        wait_drained();
        write_mixer_reg(CFG_ACTIVE, 8'h01);                  // channel 4 keeps its sample
        write_mixer_reg(CFG_SPARE, {$urandom, $urandom});
        send_beat(MODE_TICK, 3'd4, 16'sh0000);
        send_beat(MODE_TICK, 3'd0, 16'shFFFF);
        send_beat(MODE_PUSH, 3'd4, 16'sh4321);               // refused, still holds one

        // Random segments: sender-light/receiver-heavy idling, then the
        // reverse, then no idling; settings include all-zero and all-one gains.
        for (seg = 0; seg < 8; seg++) begin
            send_idle_pct = (seg < 3) ? 23 : (seg < 6) ? 63 : 0;
            recv_idle_pct = (seg < 3) ? 63 : (seg < 6) ? 23 : 0;
            case (seg)
                0:       configure(GAIN_RESET, GAIN_RESET, ACTIVE_RESET);
                1:       configure('1, '1, ACTIVE_RESET);
                2:       configure('0, '0, '0);
                default: configure(random_gain_bank(), random_gain_bank(),
                                   ACTIVE_W'($urandom_range(1, 255)));
            endcase
            run_random((seg == 2) ? 40 : 250, $urandom_range(5, 50));
        end

        // Back-pressure: long receiver hold while beats keep coming, then a
        // full pause on the input side before resuming.
        configure(GAIN_RESET, GAIN_RESET, ACTIVE_RESET);
        hold_req = 1'b1;
        run_random(60, 30);
        wait_drained();
        run_random(20, 30);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d pushes (%0d dropped, %0d refused), %0d ticks (%0d clipped)",
                 tracker.pushes, tracker.drops, tracker.refusals, tracker.ticks,
                 tracker.clips);
        $display("idle mixes both ways plus a long receiver hold; %0d mismatches",
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.due_outputs.size() == 0) begin
            $display("[multi_channel_fifo_audio_mixer] OK");
        end else begin
            $display("[multi_channel_fifo_audio_mixer] ERROR");
        end
        $finish;
    end

endmodule
